// ===== rtl/icr_pkg.sv =====
// Package for the interpolated clock reader: transaction types, clock id
// codes, register indexes and fixed arithmetic constants.
// No dependencies.
package icr_pkg;

    // Field widths
    localparam int TICK_W   = 64;
    localparam int NS_W     = 64;
    localparam int ID_W     = 6;
    localparam int CFG_W    = 32;
    localparam int SEC_W    = 35;
    localparam int NSEC_W   = 30;
    localparam int USEC_W   = 20;
    localparam int CFG_IDX_W = 1;

    // Divider constants
    localparam logic [NSEC_W-1:0] NS_PER_SEC = NSEC_W'(1000000000);
    localparam int                US_REM_W   = 10;
    localparam logic [US_REM_W-1:0] NS_PER_US = US_REM_W'(1000);
    localparam logic [CFG_W-1:0]  CAP_RESET  = CFG_W'(20000000);

    // Bits retired per cycle by the serial dividers
    localparam int DIV_DIGIT = 2;

    // Serial step counts and counter width
    localparam int MUL_STEPS = CFG_W;
    localparam int DIV_STEPS = NS_W / DIV_DIGIT;
    localparam int US_STEPS  = NSEC_W / DIV_DIGIT;
    localparam int CNT_W     = $clog2(MUL_STEPS);

    // Item kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // Result status codes
    localparam logic STATUS_OK          = 1'b0;
    localparam logic STATUS_UNSUPPORTED = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICK_SCALE = 1'b0,
        REG_INTERP_CAP = 1'b1
    } reg_idx_t;

    // Clock ids
    localparam logic [ID_W-1:0] CID_REALTIME         = 6'd0;
    localparam logic [ID_W-1:0] CID_MONOTONIC        = 6'd1;
    localparam logic [ID_W-1:0] CID_MONOTONIC_RAW    = 6'd4;
    localparam logic [ID_W-1:0] CID_REALTIME_COARSE  = 6'd5;
    localparam logic [ID_W-1:0] CID_MONOTONIC_COARSE = 6'd6;
    localparam logic [ID_W-1:0] CID_BOOTTIME         = 6'd7;
    localparam logic [ID_W-1:0] CID_BOOTTIME_ALARM   = 6'd9;
    localparam logic [ID_W-1:0] CID_TAI              = 6'd11;

    typedef enum logic [1:0] {
        FAM_MONO = 2'd0,
        FAM_REAL = 2'd1,
        FAM_NONE = 2'd2
    } fam_t;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   clock_id;
        logic [TICK_W-1:0] counter_now;
        logic [NS_W-1:0]   mono_anchor_in;
        logic [NS_W-1:0]   real_anchor_in;
    } in_item_t;

    typedef struct packed {
        logic              status;
        logic [SEC_W-1:0]  seconds;
        logic [NSEC_W-1:0] nanoseconds;
        logic [USEC_W-1:0] microseconds;
    } out_item_t;

    // Map a clock id to the anchor it reads
    function automatic fam_t clock_family(input logic [ID_W-1:0] id);
        fam_t fam;
        unique case (id) inside
            CID_REALTIME, CID_REALTIME_COARSE, CID_TAI:
                fam = FAM_REAL;
            CID_MONOTONIC, CID_MONOTONIC_RAW, CID_MONOTONIC_COARSE,
            CID_BOOTTIME, CID_BOOTTIME_ALARM:
                fam = FAM_MONO;
            default:
                fam = FAM_NONE;
        endcase
        return fam;
    endfunction

endpackage

// ===== rtl/icr_in_if.sv =====
// Input channel of the interpolated clock reader: valid/ready plus one item.
// Depends on icr_pkg.
interface icr_in_if;
    logic               valid;
    logic               ready;
    icr_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/icr_out_if.sv =====
// Result channel of the interpolated clock reader: valid/ready plus one result.
// Depends on icr_pkg.
interface icr_out_if;
    logic               valid;
    logic               ready;
    icr_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/icr_cfg_if.sv =====
// Register write channel of the interpolated clock reader: index and data.
// Depends on icr_pkg.
interface icr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [icr_pkg::CFG_IDX_W-1:0]   index;
    logic [icr_pkg::CFG_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/interpolated_clock_read.sv =====
// Interpolated clock reader, top level.
// Depends on icr_pkg, icr_in_if, icr_out_if and icr_cfg_if.
//
// A load transaction stores the monotonic, realtime and tick anchors and
// gives no result. For a read, the tick delta is formed and the multiplier
// loaded as the transaction is accepted. After that comes the bit-serial
// multiplier (one tick_scale bit per cycle), then S_ADD caps the product and
// adds it to the anchor. Then S_DIV divides by one billion, two quotient
// bits at a time, and S_USD divides the remainder by one thousand. Last,
// S_OUT moves the result into the output register. An unsupported clock
// id skips the math and goes from acceptance straight to S_OUT. One item is
// in work at a time; a finished result waits in the output register while
// the next item is taken, and only the final hand-off stalls on the result
// side. Register writes are taken at any time but must only be issued while
// the block is idle.
module interpolated_clock_read #(
    parameter int WINDOW_BITS = 40,
    parameter int SCALE_SHIFT = 20
) (
    input  logic      clk,
    input  logic      rst_n,
    icr_cfg_if.sink   cfg,
    icr_in_if.sink    in_item,
    icr_out_if.source out_item
);
    import icr_pkg::*;

    localparam int PW = WINDOW_BITS + MUL_STEPS;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_ADD  = 6'b000100,
        S_DIV  = 6'b001000,
        S_USD  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    // Control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [CFG_W-1:0]  tick_scale_reg;
    logic [CFG_W-1:0]  cap_reg;
    logic [NS_W-1:0]   mono_anchor_reg;
    logic [NS_W-1:0]   real_anchor_reg;
    logic [TICK_W-1:0] tick_anchor_reg;

    // Datapath registers
    logic                   status_reg, status_next;
    logic                   interp_en_reg, interp_en_next;
    logic [NS_W-1:0]        base_reg, base_next;
    logic [WINDOW_BITS-1:0] mcand_reg, mcand_next;
    logic [PW-1:0]          prod_reg, prod_next;
    logic [NSEC_W-1:0]      div_rem_reg, div_rem_next;
    logic [NS_W-1:0]        div_quo_reg, div_quo_next;
    logic [US_REM_W-1:0]    us_rem_reg, us_rem_next;
    logic [NSEC_W-1:0]      us_quo_reg, us_quo_next;
    out_item_t              out_data_reg, out_data_next;

    // Combinational helpers
    logic                  in_fire;
    logic                  out_free;
    fam_t                  fam;
    logic [TICK_W-1:0]     delta;
    logic [WINDOW_BITS:0]  mul_sum;
    logic [PW-1:0]         scaled;
    logic                  sat;
    logic [CFG_W-1:0]      add_ns;

    assign cfg.ready      = 1'b1;
    assign in_item.ready  = (state_reg == S_IDLE);
    assign in_fire        = in_item.valid && in_item.ready;
    assign out_free       = !out_valid_reg || out_item.ready;
    assign out_item.valid = out_valid_reg;
    assign out_item.data  = out_data_reg;

    assign fam   = clock_family(in_item.data.clock_id);
    assign delta = in_item.data.counter_now - tick_anchor_reg;

    // Multiplier step: add multiplicand on the low product bit, shift right
    assign mul_sum = {1'b0, prod_reg[PW-1:MUL_STEPS]}
                   + (prod_reg[0] ? {1'b0, mcand_reg} : '0);

    // Scale down, then saturate at the cap; zero when interpolation is off
    assign scaled = prod_reg >> SCALE_SHIFT;
    assign sat    = (|scaled[PW-1:CFG_W]) || (scaled[CFG_W-1:0] > cap_reg);
    assign add_ns = !interp_en_reg ? '0 : (sat ? cap_reg : scaled[CFG_W-1:0]);

    // Divide by one billion, DIV_DIGIT quotient bits per cycle
    always_comb
    begin
        logic [NSEC_W-1:0] r;
        logic [NS_W-1:0]   q;
        logic [NSEC_W:0]   t;
        r = div_rem_reg;
        q = div_quo_reg;
        for (int i = 0; i < DIV_DIGIT; i++)
        begin
            t = {r, q[NS_W-1]};
            q = {q[NS_W-2:0], 1'b0};
            if (t >= {1'b0, NS_PER_SEC})
            begin
                t    = t - {1'b0, NS_PER_SEC};
                q[0] = 1'b1;
            end
            r = t[NSEC_W-1:0];
        end
        div_rem_next = r;
        div_quo_next = q;
    end

    // Divide the nanosecond remainder by one thousand
    always_comb
    begin
        logic [US_REM_W-1:0] r;
        logic [NSEC_W-1:0]   q;
        logic [US_REM_W:0]   t;
        r = us_rem_reg;
        q = us_quo_reg;
        for (int i = 0; i < DIV_DIGIT; i++)
        begin
            t = {r, q[NSEC_W-1]};
            q = {q[NSEC_W-2:0], 1'b0};
            if (t >= {1'b0, NS_PER_US})
            begin
                t    = t - {1'b0, NS_PER_US};
                q[0] = 1'b1;
            end
            r = t[US_REM_W-1:0];
        end
        us_rem_next = r;
        us_quo_next = q;
    end

    // Sequencer and datapath next-state
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        interp_en_next = interp_en_reg;
        base_next      = base_reg;
        mcand_next     = mcand_reg;
        prod_next      = prod_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_item.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && in_item.data.kind == KIND_READ)
                begin
                    cnt_next       = '0;
                    interp_en_next = (tick_scale_reg != '0)
                                   && (delta[TICK_W-1:WINDOW_BITS] == '0);
                    mcand_next     = delta[WINDOW_BITS-1:0];
                    prod_next      = {{WINDOW_BITS{1'b0}}, tick_scale_reg};
                    base_next      = (fam == FAM_REAL) ? real_anchor_reg
                                                       : mono_anchor_reg;
                    if (fam == FAM_NONE)
                    begin
                        status_next = STATUS_UNSUPPORTED;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        status_next = STATUS_OK;
                        state_next  = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                prod_next = {mul_sum, prod_reg[MUL_STEPS-1:1]};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_USD;
                end
            end
            S_USD:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(US_STEPS - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.status = status_reg;
                    if (status_reg == STATUS_UNSUPPORTED)
                    begin
                        out_data_next.seconds      = '0;
                        out_data_next.nanoseconds  = '0;
                        out_data_next.microseconds = '0;
                    end
                    else
                    begin
                        out_data_next.seconds      = div_quo_reg[SEC_W-1:0];
                        out_data_next.nanoseconds  = div_rem_reg;
                        out_data_next.microseconds = us_quo_reg[USEC_W-1:0];
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers, configuration and anchors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            tick_scale_reg  <= '0;
            cap_reg         <= CAP_RESET;
            mono_anchor_reg <= '0;
            real_anchor_reg <= '0;
            tick_anchor_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;

            if (cfg.valid && cfg.ready)
            begin
                unique case (reg_idx_t'(cfg.index))
                    REG_TICK_SCALE: tick_scale_reg <= cfg.data;
                    REG_INTERP_CAP: cap_reg        <= cfg.data;
                    default: ;
                endcase
            end

            // Load transaction replaces all three anchors
            if (in_fire && in_item.data.kind == KIND_LOAD)
            begin
                mono_anchor_reg <= in_item.data.mono_anchor_in;
                real_anchor_reg <= in_item.data.real_anchor_in;
                tick_anchor_reg <= in_item.data.counter_now;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        interp_en_reg <= interp_en_next;
        base_reg      <= base_next;
        mcand_reg     <= mcand_next;
        prod_reg      <= prod_next;
        out_data_reg  <= out_data_next;

        // Anchor plus capped interpolation feeds the seconds divider
        if (state_reg == S_ADD)
        begin
            div_quo_reg <= base_reg + {{(NS_W - CFG_W){1'b0}}, add_ns};
            div_rem_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            div_quo_reg <= div_quo_next;
            div_rem_reg <= div_rem_next;
        end

        // Remainder of the seconds divide seeds the microsecond divide
        if (state_reg == S_DIV && cnt_reg == CNT_W'(DIV_STEPS - 1))
        begin
            us_quo_reg <= div_rem_next;
            us_rem_reg <= '0;
        end
        else if (state_reg == S_USD)
        begin
            us_quo_reg <= us_quo_next;
            us_rem_reg <= us_rem_next;
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for interpolated_clock_read: a table of directed
// transactions, then randomized phases, checked against fixed values or an in-bench model.
// Depends on icr_pkg, the three channel interfaces and the RTL top level.
module tb_top;
    import icr_pkg::*;

    localparam int WINDOW_BITS    = 40;
    localparam int SCALE_SHIFT    = 20;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int NUM_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 104;
    localparam int MAX_REPORTS    = 10;

    localparam logic [ID_W-1:0] KNOWN_IDS [8] = '{
        CID_REALTIME, CID_MONOTONIC, CID_MONOTONIC_RAW, CID_REALTIME_COARSE,
        CID_MONOTONIC_COARSE, CID_BOOTTIME, CID_BOOTTIME_ALARM, CID_TAI
    };

    typedef struct {
        in_item_t          item;
        bit                fixed;
        out_item_t         want;
        bit                reconfig;
        logic [CFG_W-1:0]  scale;
        logic [CFG_W-1:0]  cap;
    } dir_row_t;

    logic clk;
    logic rst_n;
    bit   idle_en;
    int   errors;
    int   cycle_count;

    // Model state: registers and anchors
    logic [CFG_W-1:0]  tick_scale_reg;
    logic [CFG_W-1:0]  cap_reg;
    logic [NS_W-1:0]   mono_base;
    logic [NS_W-1:0]   real_base;
    logic [TICK_W-1:0] tick_base;

    out_item_t expected_times[$];
    dir_row_t  dir_rows[$];

    icr_cfg_if cfg_ch ();
    icr_in_if  in_ch ();
    icr_out_if out_ch ();

    interpolated_clock_read #(
        .WINDOW_BITS (WINDOW_BITS),
        .SCALE_SHIFT (SCALE_SHIFT)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_ch),
        .in_item  (in_ch),
        .out_item (out_ch)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic in_item_t read_req(logic [ID_W-1:0] id, logic [TICK_W-1:0] cnt);
        in_item_t it;
        it.kind           = KIND_READ;
        it.clock_id       = id;
        it.counter_now    = cnt;
        it.mono_anchor_in = rand64();
        it.real_anchor_in = rand64();
        return it;
    endfunction

    function automatic in_item_t load_req(logic [TICK_W-1:0] tick, logic [NS_W-1:0] mono,
                                          logic [NS_W-1:0] rt);
        in_item_t it;
        it.kind           = KIND_LOAD;
        it.clock_id       = ID_W'($urandom_range(0, 63));
        it.counter_now    = tick;
        it.mono_anchor_in = mono;
        it.real_anchor_in = rt;
        return it;
    endfunction

    function automatic out_item_t stamp(logic st, logic [SEC_W-1:0] sec,
                                        logic [NSEC_W-1:0] ns, logic [USEC_W-1:0] us);
        out_item_t r;
        r.status       = st;
        r.seconds      = sec;
        r.nanoseconds  = ns;
        r.microseconds = us;
        return r;
    endfunction

    // Expected timestamp for a read, from the current anchors and registers
    function automatic out_item_t predict_time(in_item_t it);
        out_item_t    r;
        logic [63:0]  delta;
        logic [63:0]  add;
        logic [63:0]  total;
        logic [63:0]  nsec;
        logic [127:0] scaled;
        bit           is_real;
        bit           known;
        r       = '0;
        known   = 1'b1;
        is_real = 1'b0;
        case (it.clock_id)
            CID_REALTIME, CID_REALTIME_COARSE, CID_TAI:
                is_real = 1'b1;
            CID_MONOTONIC, CID_MONOTONIC_RAW, CID_MONOTONIC_COARSE,
            CID_BOOTTIME, CID_BOOTTIME_ALARM:
                is_real = 1'b0;
            default:
                known = 1'b0;
        endcase
        if (!known)
        begin
            r.status = STATUS_UNSUPPORTED;
            return r;
        end
        // Interpolate only inside the tick window and with a nonzero rate
        delta = it.counter_now - tick_base;
        add   = '0;
        if (tick_scale_reg != '0 && delta < (64'd1 << WINDOW_BITS))
        begin
            scaled = ({64'd0, delta} * {96'd0, tick_scale_reg}) >> SCALE_SHIFT;
            add    = (scaled > {96'd0, cap_reg}) ? {32'd0, cap_reg} : scaled[63:0];
        end
        total = (is_real ? real_base : mono_base) + add;
        nsec  = total % 64'(NS_PER_SEC);
        r.status       = STATUS_OK;
        r.seconds      = SEC_W'(total / 64'(NS_PER_SEC));
        r.nanoseconds  = NSEC_W'(nsec);
        r.microseconds = USEC_W'(nsec / 64'(NS_PER_US));
        return r;
    endfunction

    task automatic add_row(in_item_t it, bit fixed, out_item_t want, bit reconfig,
                           logic [CFG_W-1:0] scale, logic [CFG_W-1:0] cap);
        dir_row_t row;
        row.item     = it;
        row.fixed    = fixed;
        row.want     = want;
        row.reconfig = reconfig;
        row.scale    = scale;
        row.cap      = cap;
        dir_rows.push_back(row);
    endtask

    // One input transaction; the model is updated at acceptance
    task automatic send_item(in_item_t it, bit fixed, out_item_t want);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge clk); while (!in_ch.ready);
        if (it.kind == KIND_LOAD)
        begin
            mono_base = it.mono_anchor_in;
            real_base = it.real_anchor_in;
            tick_base = it.counter_now;
        end
        else
            expected_times.push_back(fixed ? want : predict_time(it));
    endtask

    // One register write; the caller drops valid after the last write
    task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            REG_TICK_SCALE: tick_scale_reg = val;
            REG_INTERP_CAP: cap_reg = val;
            default: ;
        endcase
    endtask

    // Drop valid, wait for all results, then let a possible load finish
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (expected_times.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random transaction: mostly reads near the tick anchor, some loads
    task automatic next_item(output in_item_t it);
        logic [TICK_W-1:0] delta;
        logic [ID_W-1:0]   id;
        int                roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            it = load_req(rand64() >> $urandom_range(0, 63), rand64() >> $urandom_range(0, 63),
                          rand64() >> $urandom_range(0, 63));
        else
        begin
            id    = (roll < 85) ? KNOWN_IDS[$urandom_range(0, 7)]
                                : ID_W'($urandom_range(0, 63));
            delta = rand64() >> $urandom_range(0, 63);
            if ($urandom_range(0, 9) == 0)
                delta = rand64();
            it = read_req(id, tick_base + delta);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin : check_result
        out_item_t want;
        out_item_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (expected_times.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: status %0d sec %0d ns %0d us %0d",
                             got.status, got.seconds, got.nanoseconds, got.microseconds);
            end
            else
            begin
                want = expected_times.pop_front();
                if (got.status != want.status || got.seconds != want.seconds ||
                    got.nanoseconds != want.nanoseconds ||
                    got.microseconds != want.microseconds)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display({"mismatch: exp status %0d sec %0d ns %0d us %0d, ",
                                  "got status %0d sec %0d ns %0d us %0d"},
                                 want.status, want.seconds, want.nanoseconds,
                                 want.microseconds, got.status, got.seconds,
                                 got.nanoseconds, got.microseconds);
                end
            end
        end
    end

    // Result side back-pressure in random bursts
    initial
    begin
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (idle_en && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // Main sequence
    initial
    begin
        in_item_t         it;
        logic [CFG_W-1:0] scale;
        logic [CFG_W-1:0] cap;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        idle_en        = 1'b1;
        errors         = 0;
        cycle_count    = 0;
        tick_scale_reg = '0;
        cap_reg        = CAP_RESET;
        mono_base      = '0;
        real_base      = '0;
        tick_base      = '0;

        // Directed rows; reset config: no interpolation, anchors zero
        add_row(read_req(CID_REALTIME, 64'd0), 1, stamp(STATUS_OK, 0, 0, 0), 0, 0, 0);
        add_row(read_req(CID_MONOTONIC, '1), 1, stamp(STATUS_OK, 0, 0, 0), 0, 0, 0);
        add_row(read_req(6'd63, 64'd0), 1, stamp(STATUS_UNSUPPORTED, 0, 0, 0), 0, 0, 0);
        add_row(read_req(6'd2, '1), 1, stamp(STATUS_UNSUPPORTED, 0, 0, 0), 0, 0, 0);
        add_row(load_req(64'd100, '1, 64'd999999999), 0, '0, 0, 0, 0);
        add_row(read_req(CID_MONOTONIC_RAW, 64'd100), 1,
                stamp(STATUS_OK, 35'd18446744073, 30'd709551615, 20'd709551), 0, 0, 0);
        add_row(read_req(CID_TAI, 64'd5000), 1,
                stamp(STATUS_OK, 0, 30'd999999999, 20'd999999), 0, 0, 0);
        // Largest rate and cap: window edges, anchor wrap
        add_row(read_req(CID_MONOTONIC_COARSE, 64'd100), 0, '0, 1, '1, '1);
        add_row(read_req(CID_REALTIME_COARSE, 64'd101), 0, '0, 0, 0, 0);
        add_row(read_req(CID_BOOTTIME, 64'd100 + (64'd1 << WINDOW_BITS) - 64'd1), 0, '0, 0, 0, 0);
        add_row(read_req(CID_BOOTTIME_ALARM, 64'd100 + (64'd1 << WINDOW_BITS)), 0, '0, 0, 0, 0);
        add_row(read_req(CID_REALTIME, 64'd99), 0, '0, 0, 0, 0);
        add_row(load_req('1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFA), 0, '0, 0, 0, 0);
        add_row(read_req(CID_REALTIME, 64'd3), 0, '0, 0, 0, 0);
        // One ns per tick with a zero cap, then a small cap
        add_row(read_req(CID_MONOTONIC, 64'd1000), 0, '0, 1, 32'd1 << SCALE_SHIFT, 32'd0);
        add_row(read_req(CID_MONOTONIC, 64'd400), 0, '0, 1, 32'd1 << SCALE_SHIFT, 32'd500);
        add_row(read_req(CID_MONOTONIC, 64'd2000), 0, '0, 0, 0, 0);
        add_row(read_req(6'd10, 64'd7), 1, stamp(STATUS_UNSUPPORTED, 0, 0, 0), 0, 0, 0);
        add_row(read_req(6'd8, 64'd7), 1, stamp(STATUS_UNSUPPORTED, 0, 0, 0), 0, 0, 0);
        add_row(read_req(6'd3, 64'd7), 1, stamp(STATUS_UNSUPPORTED, 0, 0, 0), 0, 0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].reconfig)
            begin
                settle();
                write_reg(REG_TICK_SCALE, dir_rows[i].scale);
                write_reg(REG_INTERP_CAP, dir_rows[i].cap);
                cfg_ch.valid <= 1'b0;
            end
            send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);
        end

        // Random phases, each under its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            idle_en = (ph != NUM_PHASES - 1);
            case (ph)
                0: begin scale = 32'd1 << SCALE_SHIFT; cap = CAP_RESET; end
                1: begin scale = '0; cap = '0; end
                2: begin scale = '1; cap = '1; end
                3: begin scale = 32'd1; cap = '1; end
                default:
                begin
                    scale = $urandom >> $urandom_range(0, 31);
                    cap   = $urandom >> $urandom_range(0, 31);
                end
            endcase
            write_reg(REG_TICK_SCALE, scale);
            write_reg(REG_INTERP_CAP, cap);
            cfg_ch.valid <= 1'b0;
            repeat (ITEMS_PER_PHASE)
            begin
                next_item(it);
                send_item(it, 0, '0);
            end
        end

        settle();
        if (errors == 0 && expected_times.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/icr_pkg.sv
rtl/icr_in_if.sv
rtl/icr_out_if.sv
rtl/icr_cfg_if.sv
rtl/interpolated_clock_read.sv
tb/tb_top.sv
